>>> rtl/setm_pkg.sv
// ----------------------------------------------------------------------------
// setm_pkg
// Shared types, constants and the emoticon symbol table of the token matcher.
// ----------------------------------------------------------------------------
package setm_pkg;

  localparam int SYMBOL_COUNT   = 96;
  localparam int MAX_SYMBOL_LEN = 11;
  localparam int BUF_DEPTH      = MAX_SYMBOL_LEN + 1;
  localparam logic [7:0] SLASH  = 8'h2F;

  // Strings are right-justified: the last character sits in bits 7:0.
  localparam logic [8*MAX_SYMBOL_LEN-1:0] SYM_TAB [SYMBOL_COUNT] = '{
    ":)", ":~", ":*", ":|", "8-)", ":<", ":$", ":X", ":Z", ":'(",
    ":-|", ":@", ":P", ":D", ":O", "<rotate>", ":(", ":+", ":lenhan", ":Q",
    ":T", ";P", ";-D", ";d", ";o", ":g", "|-)", ":!", ":L", ":>",
    ";bin", ":fw", ";fd", ":-S", ";?", ";x", ";@", ":8", ";!", "!!!",
    ":xx", ":bye", ":csweat", ":knose", ":applause", ":cdale", ":huaixiao",
    ":shake", ":lhenhen", ":rhenhen", ":yawn", ":snooty", ":chagrin",
    ":kcry", ":yinxian", ":qinqin", ":xiaren", ":kelin", ":caidao", ":xig",
    ":bj", ":basketball", ":pingpong", ":jump", ":coffee", ":eat", ":pig",
    ":rose", ":fade", ":kiss", ":heart", ":break", ":cake", ":shd", ":bomb",
    ":dao", ":footb", ":piaocon", ":shit", ":oh", ":moon", ":sun", ";gift",
    ":hug", ":strong", ";weak", ":share", ":shl", ":baoquan", ":cajole",
    ":quantou", ":chajin", ":aini", ":sayno", ":sayok", ":love"
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_JUDGE,
    ST_SHIFT
  } st_t;

  typedef struct packed {
    logic       is_emo;
    logic [7:0] text;
    logic [6:0] id;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       decided;
    logic       matched;
    logic [6:0] id;
    logic [3:0] mlen;
  } judge_t;

  typedef struct packed {
    logic       shift;
    logic       load;
    logic [3:0] load_idx;
    logic [7:0] load_byte;
  } chain_ctl_t;

  function automatic logic [3:0] sym_len(input int j);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < MAX_SYMBOL_LEN; k++) begin
      if (SYM_TAB[j][k*8 +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] sym_char(input int j, input int k);
    int pos;
    pos = int'(sym_len(j)) - 1 - k;
    if (pos < 0) pos = 0;
    return SYM_TAB[j][pos*8 +: 8];
  endfunction

endpackage

>>> rtl/setm_cell.sv
// ----------------------------------------------------------------------------
// setm_cell
// One byte cell of the held-byte chain: loads or takes its right neighbor.
// ----------------------------------------------------------------------------
module setm_cell (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_byte,
  input  logic       shift,
  input  logic [7:0] right_byte,
  output logic [7:0] byte_q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = load_byte;
    end else if (shift) begin
      byte_nxt = right_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

>>> rtl/setm_chain.sv
// ----------------------------------------------------------------------------
// setm_chain
// Row of byte cells; cell 0 is the head, a shift moves every byte one left.
// ----------------------------------------------------------------------------
module setm_chain
  import setm_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  output logic [7:0] bytes [BUF_DEPTH]
);

  for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
    logic [7:0] right;
    if (i == BUF_DEPTH - 1) begin : g_end
      assign right = 8'd0;
    end else begin : g_mid
      assign right = bytes[i+1];
    end
    setm_cell u_cell (
      .clk        (clk),
      .load       (ctl.load && (ctl.load_idx == 4'(i))),
      .load_byte  (ctl.load_byte),
      .shift      (ctl.shift),
      .right_byte (right),
      .byte_q     (bytes[i])
    );
  end

endmodule

>>> rtl/setm_judge.sv
// ----------------------------------------------------------------------------
// setm_judge
// Compares the held bytes against every table entry, first entry wins.
// ----------------------------------------------------------------------------
module setm_judge
  import setm_pkg::*;
(
  input  logic [7:0] bytes [BUF_DEPTH],
  input  logic [3:0] cnt,
  input  logic       ended,
  output judge_t     res
);

  logic [SYMBOL_COUNT-1:0] cons;
  logic [SYMBOL_COUNT-1:0] comp;
  logic [SYMBOL_COUNT-1:0] sel;

  always_comb begin
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      cons[j] = (sym_len(j) != 4'd0);
      for (int k = 0; k < MAX_SYMBOL_LEN; k++) begin
        if ((4'(k) < cnt) && (4'(k) < sym_len(j)) && (bytes[k] != sym_char(j, k))) begin
          cons[j] = 1'b0;
        end
      end
      comp[j] = (cnt >= sym_len(j));
    end
  end

  // while waiting, an incomplete consistent entry holds the decision back
  assign sel = ended ? (cons & comp) : cons;

  always_comb begin
    logic       found;
    logic [6:0] first;
    found = 1'b0;
    first = '0;
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      if (sel[j] && !found) begin
        found = 1'b1;
        first = 7'(j);
      end
    end
    res.matched = found && comp[first];
    res.decided = !found || comp[first];
    res.id      = first + 7'd1;
    res.mlen    = found ? sym_len(int'(first)) : 4'd0;
  end

endmodule

>>> rtl/slash_emoticon_token_matcher_top.sv
// ----------------------------------------------------------------------------
// slash_emoticon_token_matcher_top
// Turns a message byte stream into literal bytes and emoticon tokens.
// ----------------------------------------------------------------------------
// Input channel in_*: one message byte per transfer in in_tdata, in_tlast on
// the last byte of a message. Output channel out_*: one result per transfer,
// out_tuser = 1 for an emoticon token, out_tdata holds text byte and id,
// out_tlast marks the final result of a message.
// An item is taken in the idle state only. A plain byte or a '/' is
// accepted, then passed on or opens the escape, and the item finishes. A
// byte held after a '/' is accepted, appended, compared with the table and
// the item finishes; a match then shifts the symbol bytes out. Replayed
// bytes after a mismatch pass as plain text, or are appended and compared
// in a reopened escape; an escape open at message end is judged once more.
// The last result of each item is held in a staging register and moves to
// the output register once the item is done, so that tlast can be set on it.
// The 96-entry compare is a combinational priority search over the held bytes.
// Synchronous active-low reset clears the byte count, closes any escape and
// drops pending results. When the receiver stalls, results back up into the
// staging and output registers and the sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
module slash_emoticon_token_matcher_top
  import setm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] text_byte, [14:8] emoticon_id, [15] zero
  output logic        out_tuser,  // [0] is_emoticon
  output logic        out_tlast
);

  st_t        state_r, state_nxt;
  logic [3:0] n_r, n_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] shamt_r, shamt_nxt;
  logic       as_r, as_nxt;
  logic       eom_r, eom_nxt;
  logic       ended_r, ended_nxt;
  logic       st_v_r, st_v_nxt;
  logic       out_v_r, out_v_nxt;
  res_t       st_r, st_nxt;
  res_t       out_r, out_nxt;

  logic [7:0] bytes [BUF_DEPTH];
  chain_ctl_t ctl;
  judge_t     jr;
  logic       emit;
  logic       flush;
  res_t       new_res;
  logic       can_emit;
  logic       slot_free;

  setm_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .bytes (bytes)
  );

  setm_judge u_judge (
    .bytes (bytes),
    .cnt   (cnt_r),
    .ended (ended_r),
    .res   (jr)
  );

  assign slot_free = !out_v_r || out_tready;
  assign can_emit  = !st_v_r || slot_free;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    shamt_nxt     = shamt_r;
    as_nxt        = as_r;
    eom_nxt       = eom_r;
    ended_nxt     = ended_r;
    ctl.shift     = 1'b0;
    ctl.load      = 1'b0;
    ctl.load_idx  = n_r;
    ctl.load_byte = in_tdata;
    emit          = 1'b0;
    flush         = 1'b0;
    new_res       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          n_nxt     = n_r + 4'd1;
          eom_nxt   = in_tlast;
          ended_nxt = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r < n_r) begin
          if (as_r) begin
            cnt_nxt   = cnt_r + 4'd1;
            ended_nxt = 1'b0;
            state_nxt = ST_JUDGE;
          end else if (bytes[0] == SLASH) begin
            as_nxt    = 1'b1;
            ctl.shift = 1'b1;
            n_nxt     = n_r - 4'd1;
          end else if (can_emit) begin
            emit         = 1'b1;
            new_res.text = bytes[0];
            ctl.shift    = 1'b1;
            n_nxt        = n_r - 4'd1;
          end
        end else if (eom_r && as_r) begin
          ended_nxt = 1'b1;
          state_nxt = ST_JUDGE;
        end else if (!st_v_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          flush     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_JUDGE: begin
        if (!jr.decided) begin
          state_nxt = ST_RUN;
        end else if (can_emit) begin
          emit = 1'b1;
          if (jr.matched) begin
            new_res.is_emo = 1'b1;
            new_res.id     = jr.id;
            shamt_nxt      = jr.mlen;
            state_nxt      = (jr.mlen != 4'd0) ? ST_SHIFT : ST_RUN;
          end else begin
            new_res.text = SLASH;
            shamt_nxt    = 4'd0;
            state_nxt    = ST_RUN;
          end
          as_nxt  = 1'b0;
          cnt_nxt = 4'd0;
        end
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        n_nxt     = n_r - 4'd1;
        shamt_nxt = shamt_r - 4'd1;
        if (shamt_r == 4'd1) state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_tready;
    st_nxt    = st_r;
    st_v_nxt  = st_v_r;
    if (emit) begin
      if (st_v_r) begin
        out_nxt   = st_r;
        out_v_nxt = 1'b1;
      end
      st_nxt   = new_res;
      st_v_nxt = 1'b1;
    end
    if (flush) begin
      out_nxt      = st_r;
      out_nxt.last = eom_r;
      out_v_nxt    = 1'b1;
      st_v_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      cnt_r   <= '0;
      shamt_r <= '0;
      as_r    <= 1'b0;
      eom_r   <= 1'b0;
      ended_r <= 1'b0;
      st_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      cnt_r   <= cnt_nxt;
      shamt_r <= shamt_nxt;
      as_r    <= as_nxt;
      eom_r   <= eom_nxt;
      ended_r <= ended_nxt;
      st_v_r  <= st_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    out_r <= out_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.id, out_r.text};
  assign out_tuser  = out_r.is_emo;
  assign out_tlast  = out_r.last;

endmodule

>>> rtl/setm_checker.sv
// ----------------------------------------------------------------------------
// setm_checker
// Port-level checks of the token matcher, bound to the top level.
// ----------------------------------------------------------------------------
module setm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_token_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0 && out_tdata[14:8] != 7'd0
      && out_tdata[14:8] <= 7'd96)
    else $error("bad emoticon token fields");

  a_literal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:8] == 8'd0)
    else $error("literal carries an id");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result present after reset");

endmodule

bind slash_emoticon_token_matcher_top setm_checker u_setm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> bench/slash_emoticon_token_matcher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slash_emoticon_token_matcher_top_test
// Streams message bytes with '/'-escaped emoticon symbols into the matcher,
// predicts the literal and token stream in the bench, and checks each output
// transfer in order under random source and sink stalls.
// ----------------------------------------------------------------------------
module slash_emoticon_token_matcher_top_test;
  import setm_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_item_t;

  typedef struct {
    logic       is_emo;
    logic [7:0] text;
    logic [6:0] id;
    logic       last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  slash_emoticon_token_matcher_top dut (.*);

  // bench copy of the symbol table, left-justified strings
  string emo_names[SYMBOL_COUNT] = '{
    ":)", ":~", ":*", ":|", "8-)", ":<", ":$", ":X", ":Z", ":'(",
    ":-|", ":@", ":P", ":D", ":O", "<rotate>", ":(", ":+", ":lenhan", ":Q",
    ":T", ";P", ";-D", ";d", ";o", ":g", "|-)", ":!", ":L", ":>",
    ";bin", ":fw", ";fd", ":-S", ";?", ";x", ";@", ":8", ";!", "!!!",
    ":xx", ":bye", ":csweat", ":knose", ":applause", ":cdale", ":huaixiao",
    ":shake", ":lhenhen", ":rhenhen", ":yawn", ":snooty", ":chagrin",
    ":kcry", ":yinxian", ":qinqin", ":xiaren", ":kelin", ":caidao", ":xig",
    ":bj", ":basketball", ":pingpong", ":jump", ":coffee", ":eat", ":pig",
    ":rose", ":fade", ":kiss", ":heart", ":break", ":cake", ":shd", ":bomb",
    ":dao", ":footb", ":piaocon", ":shit", ":oh", ":moon", ":sun", ";gift",
    ":hug", ":strong", ";weak", ":share", ":shl", ":baoquan", ":cajole",
    ":quantou", ":chajin", ":aini", ":sayno", ":sayok", ":love"
  };

  msg_item_t  pending_bytes[$];
  token_t     expected_tokens[$];
  logic [7:0] held[$];
  logic       in_escape;

  int errors;
  int mismatches;
  int bytes_sent;
  int tokens_seen;
  int emo_seen;
  int idle_cycles;
  int src_gap;
  int snk_gap;
  bit calm;
  bit stim_done;
  bit in_taken;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void push_token(logic is_emo, logic [7:0] text, logic [6:0] id);
    token_t t;
    t.is_emo = is_emo;
    t.text   = text;
    t.id     = id;
    t.last   = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // -1 keep waiting, 0 no entry, else id; mlen gets symbol length
  function automatic int search_table(bit ended, output int mlen);
    int len;
    int n;
    bit ok;
    mlen = 0;
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      len = emo_names[j].len();
      if (len == 0 || len > MAX_SYMBOL_LEN) continue;
      n = (held.size() < len) ? held.size() : len;
      ok = 1;
      for (int k = 0; k < n; k++) begin
        if (emo_names[j][k] != held[k]) ok = 0;
      end
      if (!ok) continue;
      if (held.size() >= len) begin
        mlen = len;
        return j + 1;
      end
      if (!ended) return -1;
    end
    return 0;
  endfunction

  function automatic void settle_escape(bit ended);
    logic [7:0] rest[$];
    int hit;
    int mlen;
    hit = search_table(ended, mlen);
    if (hit < 0) return;
    rest = held;
    held.delete();
    in_escape = 1'b0;
    if (hit > 0) begin
      push_token(1'b1, 8'h00, 7'(hit));
    end else begin
      push_token(1'b0, SLASH, 7'd0);
    end
    for (int k = mlen; k < rest.size(); k++) scan_byte(rest[k]);
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    if (!in_escape) begin
      if (b == SLASH) begin
        in_escape = 1'b1;
        held.delete();
      end else begin
        push_token(1'b0, b, 7'd0);
      end
      return;
    end
    if (held.size() < MAX_SYMBOL_LEN) held.push_back(b);
    settle_escape(1'b0);
  endfunction

  function automatic void predict_tokens(msg_item_t it);
    int before_n;
    before_n = expected_tokens.size();
    scan_byte(it.data);
    if (it.last) begin
      while (in_escape) settle_escape(1'b1);
      if (expected_tokens.size() > before_n)
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // input transfers are taken at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      predict_tokens('{data: in_tdata, last: in_tlast});
      bytes_sent++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(1, 10);
            in_tvalid <= 1'b0;
          end else begin
            in_tvalid <= 1'b1;
            in_tdata  <= pending_bytes[0].data;
            in_tlast  <= pending_bytes[0].last;
            void'(pending_bytes.pop_front());
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(1, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      tokens_seen++;
      if (out_tuser) emo_seen++;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected output: tdata=%h tuser=%b tlast=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser !== want.is_emo || out_tdata[7:0] !== want.text ||
            out_tdata[14:8] !== want.id || out_tdata[15] !== 1'b0 ||
            out_tlast !== want.last) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch #%0d: exp emo=%b text=%h id=%0d last=%b, ",
                      "got tuser=%b tdata=%h tlast=%b"},
                     tokens_seen, want.is_emo, want.text, want.id, want.last,
                     out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_byte(logic [7:0] b, logic last);
    pending_bytes.push_back('{data: b, last: last});
  endtask

  task automatic add_text(string s, logic last_at_end);
    for (int k = 0; k < s.len(); k++)
      add_byte(s[k], last_at_end && (k == s.len() - 1));
  endtask

  task automatic add_random_message();
    int parts;
    int sel;
    string sym;
    parts = $urandom_range(1, 4);
    for (int p = 0; p < parts; p++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        sym = emo_names[$urandom_range(0, SYMBOL_COUNT - 1)];
        add_byte(SLASH, 1'b0);
        // sometimes a truncated or corrupted symbol
        if ($urandom_range(0, 3) == 0) sym = sym.substr(0, $urandom_range(0, sym.len() - 1));
        add_text(sym, 1'b0);
        if ($urandom_range(0, 4) == 0) add_byte(8'($urandom), 1'b0);
      end else if (sel < 8) begin
        add_byte(8'($urandom_range(32, 126)), 1'b0);
      end else begin
        add_byte(8'($urandom), 1'b0);
      end
    end
    add_byte(($urandom_range(0, 3) == 0) ? SLASH : 8'($urandom), 1'b1);
  endtask

  initial begin
    errors = 0; mismatches = 0; bytes_sent = 0; tokens_seen = 0; emo_seen = 0;
    idle_cycles = 0; src_gap = 0; snk_gap = 0; calm = 0; stim_done = 0;
    in_taken = 0;
    in_escape = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 8'h00; in_tlast = 1'b0; out_tready = 1'b0;

    // directed: extremes, end inside escape, slash last
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_text("/:)a", 1'b1);
    add_text("/:lenhan", 1'b0);
    add_text("/:basketbal", 1'b1);
    add_text("/;-X/", 1'b1);
    add_text("//:D", 1'b1);
    add_text("/<rotat", 1'b1);
    add_text("/:b", 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() < 110) add_random_message();
    wait (pending_bytes.size() < 30);
    calm = 1;
    wait (pending_bytes.size() == 0 && !in_tvalid);
    wait (expected_tokens.size() == 0);
    repeat (50) @(posedge clk);

    $display("sent %0d message bytes, checked %0d results (%0d emoticon tokens)",
             bytes_sent, tokens_seen, emo_seen);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
